// ===== rtl/core/fab_pkg.sv =====
// ----------------------------------------------------------------------------
// fab_pkg
// Shared constants, codes and controller/datapath interface types for the
// frame bitmap allocator.
// ----------------------------------------------------------------------------
package fab_pkg;

   localparam int NUM_FRAMES_DEF = 1024;
   localparam int WORD_BITS_DEF  = 32;

   localparam int OP_W    = 2;
   localparam int IDX_W   = 10;
   localparam int STAT_W  = 2;
   localparam int CFG_W   = 11;
   localparam int TDATA_W = 16;

   localparam logic [CFG_W-1:0] FRAMES_RESET = 11'd1024;

   localparam logic [OP_W-1:0] OP_ALLOC_FIRST = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC_AT    = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE        = 2'd2;
   localparam logic [OP_W-1:0] OP_TEST        = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK            = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_FREE       = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_ALLOCATED = 2'd2;
   localparam logic [STAT_W-1:0] ST_RANGE         = 2'd3;

   typedef struct packed {
      logic capture;   // take the request beat into the datapath
      logic fetch;     // read the first word of the request
      logic advance;   // read the next bitmap word
      logic commit;    // write back and load the result register
   } cmd_type;

   typedef struct packed {
      logic alloc_first;
      logic word_full;
      logic last_word;
      logic out_busy;
   } stat_type;

endpackage

// ===== rtl/core/fab_ctrl.sv =====
// ----------------------------------------------------------------------------
// fab_ctrl
// Sequencer: accepts a request, fetches its bitmap word, walks words for a
// first-free search and commits once the result register is free.
// ----------------------------------------------------------------------------
module fab_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  fab_pkg::stat_type stat,
   output fab_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_EVAL  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            if (stat.alloc_first && stat.word_full && !stat.last_word) begin
               cmd.advance = 1'b1;
            end else if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/fab_dp.sv =====
// ----------------------------------------------------------------------------
// fab_dp
// Bitmap word memory with per-word valid bits, word evaluation, write-back
// and the result register. WORD_BITS is a power of two.
// ----------------------------------------------------------------------------
module fab_dp #(
   parameter int NUM_FRAMES = fab_pkg::NUM_FRAMES_DEF,
   parameter int WORD_BITS  = fab_pkg::WORD_BITS_DEF,
   parameter int LIM_W      = fab_pkg::CFG_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fab_pkg::cmd_type            cmd,
   output fab_pkg::stat_type           stat,
   input  logic [fab_pkg::OP_W-1:0]    req_opcode,
   input  logic [fab_pkg::IDX_W-1:0]   req_frame_index,
   input  logic [LIM_W-1:0]            limit,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [fab_pkg::TDATA_W-1:0] rsp_tdata
);

   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int FIDX_W    = ADDR_W + BIT_W;
   localparam int XW        = (FIDX_W > fab_pkg::IDX_W) ? FIDX_W : fab_pkg::IDX_W;
   localparam int CW        = (XW > LIM_W) ? XW : LIM_W;
   localparam int PAD_W     = fab_pkg::TDATA_W - fab_pkg::IDX_W - fab_pkg::STAT_W - 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] vld_ff;

   logic [fab_pkg::OP_W-1:0]    op_ff;
   logic [XW-1:0]               idx_ff;
   logic [ADDR_W-1:0]           rd_addr_ff;
   logic [ADDR_W-1:0]           rd_addr_in;
   logic [WORD_BITS-1:0]        rd_word_ff;
   logic                        rd_vld_ff;
   logic                        rsp_tvalid_ff;
   logic [fab_pkg::TDATA_W-1:0] rsp_tdata_ff;

   logic [WORD_BITS-1:0]        word;
   logic [WORD_BITS-1:0]        free_bits;
   logic                        full;
   logic [BIT_W-1:0]            first_bit;
   logic [FIDX_W-1:0]           found_frame;
   logic [BIT_W-1:0]            idx_bit;
   logic [WORD_BITS-1:0]        idx_mask;
   logic                        old_bit;
   logic                        in_range;
   logic                        set_en;
   logic                        wr_en;
   logic [WORD_BITS-1:0]        wr_word;
   logic [XW-1:0]               res_frame;
   logic [fab_pkg::STAT_W-1:0]  res_status;
   logic                        res_used;

   // read address: request word on fetch, next word while scanning
   always_comb begin
      if (cmd.fetch) begin
         if (op_ff == fab_pkg::OP_ALLOC_FIRST) begin
            rd_addr_in = '0;
         end else begin
            rd_addr_in = idx_ff[FIDX_W-1:BIT_W];
         end
      end else if (cmd.advance) begin
         rd_addr_in = rd_addr_ff + ADDR_W'(1);
      end else begin
         rd_addr_in = rd_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[rd_addr_ff] <= wr_word;
      end
      rd_word_ff <= mem[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[rd_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      rd_vld_ff  <= vld_ff[rd_addr_in];
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         idx_ff <= XW'(req_frame_index);
      end
   end

   // a word never written reads as all free
   assign word      = rd_vld_ff ? rd_word_ff : '0;
   assign free_bits = ~word;
   assign full      = (free_bits == '0);

   always_comb begin
      first_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            first_bit = BIT_W'(b);
         end
      end
   end

   assign found_frame = {rd_addr_ff, first_bit};
   assign idx_bit     = idx_ff[BIT_W-1:0];
   assign idx_mask    = WORD_BITS'(1) << idx_bit;
   assign old_bit     = word[idx_bit];
   assign in_range    = CW'(idx_ff) < CW'(limit);

   always_comb begin
      set_en     = 1'b0;
      wr_word    = word;
      res_frame  = '0;
      res_status = fab_pkg::ST_OK;
      res_used   = 1'b0;
      if (op_ff == fab_pkg::OP_ALLOC_FIRST) begin
         // the lowest clear bit must also lie below the limit
         if (!full && (CW'(found_frame) < CW'(limit))) begin
            set_en    = 1'b1;
            wr_word   = word | (WORD_BITS'(1) << first_bit);
            res_frame = XW'(found_frame);
         end else begin
            res_status = fab_pkg::ST_NO_FREE;
         end
      end else if (!in_range) begin
         res_status = fab_pkg::ST_RANGE;
      end else begin
         case (op_ff)
            fab_pkg::OP_ALLOC_AT: begin
               set_en    = 1'b1;
               wr_word   = word | idx_mask;
               res_frame = idx_ff;
               res_used  = old_bit;
            end
            fab_pkg::OP_FREE: begin
               if (old_bit) begin
                  set_en    = 1'b1;
                  wr_word   = word & ~idx_mask;
                  res_frame = idx_ff;
                  res_used  = 1'b1;
               end else begin
                  res_status = fab_pkg::ST_NOT_ALLOCATED;
               end
            end
            default: begin
               res_frame = idx_ff;
               res_used  = old_bit;
            end
         endcase
      end
   end

   assign wr_en = cmd.commit & set_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_tdata_ff <= {{PAD_W{1'b0}}, res_used, res_status,
                          res_frame[fab_pkg::IDX_W-1:0]};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign stat.alloc_first = (op_ff == fab_pkg::OP_ALLOC_FIRST);
   assign stat.word_full   = full;
   assign stat.last_word   = (rd_addr_ff == LAST_ADDR);
   assign stat.out_busy    = rsp_tvalid_ff & ~rsp_tready;

   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid_ff)
      else $error("result register not loaded after commit");

   a_commit_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_tvalid_ff && !rsp_tready))
      else $error("commit over a result still waiting");

   a_nofree_only_first: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && res_status == fab_pkg::ST_NO_FREE)
         |-> (op_ff == fab_pkg::OP_ALLOC_FIRST))
      else $error("no-free status on a given-frame request");

   a_frame_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tdata_ff[fab_pkg::IDX_W +: fab_pkg::STAT_W] != fab_pkg::ST_OK)
         |-> (rsp_tdata_ff[fab_pkg::IDX_W-1:0] == '0))
      else $error("frame not zero on error status");

   a_write_on_commit: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cmd.commit && res_status == fab_pkg::ST_OK))
      else $error("bitmap written outside an ok commit");

endmodule

// ===== rtl/core/frame_bitmap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core
// First-fit page frame allocator over a used/free bitmap.
// ----------------------------------------------------------------------------
// Requests come in on req_* as stream beats (opcode, frame index) and each
// one produces exactly one beat on rsp_* (frame, status, was_used).
// csr_wr_en/csr_wr_data set the frames-in-use limit; write it only while idle.
// A given-frame request (allocate at, free, test) is captured, its word read,
// then evaluated and written back once the output register is free, and the
// commit raises rsp_tvalid. Allocate-first-free reads one bitmap word per
// cycle until it meets a word with a clear bit or reaches the last word.
// A new request is taken the cycle after the previous one has committed, so
// none is accepted while the previous one is in progress. Reset clears the
// bitmap through per-word valid bits and sets the limit to 1024. A result
// waits in the output register while rsp_tready is low; the next request is
// still accepted and processed, and only its commit waits for the register
// to drain.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core #(
   parameter int NUM_FRAMES = fab_pkg::NUM_FRAMES_DEF,
   parameter int WORD_BITS  = fab_pkg::WORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [fab_pkg::TDATA_W-1:0] req_tdata,   // opcode[1:0], frame_index[11:2]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [fab_pkg::TDATA_W-1:0] rsp_tdata,   // result_frame[9:0], status[11:10],
                                                    // was_used[12]
   input  logic                        csr_wr_en,
   input  logic [fab_pkg::CFG_W-1:0]   csr_wr_data
);

   localparam int NF_W  = $clog2(NUM_FRAMES + 1);
   localparam int LIM_W = (NF_W > fab_pkg::CFG_W) ? NF_W : fab_pkg::CFG_W;

   logic [fab_pkg::CFG_W-1:0] frames_ff;
   logic [LIM_W-1:0]          limit;
   fab_pkg::cmd_type          cmd;
   fab_pkg::stat_type         stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= fab_pkg::FRAMES_RESET;
      end else if (csr_wr_en) begin
         frames_ff <= csr_wr_data;
      end
   end

   // limit saturates at the number of frames the map holds
   assign limit = (LIM_W'(frames_ff) > LIM_W'(NUM_FRAMES)) ? LIM_W'(NUM_FRAMES)
                                                           : LIM_W'(frames_ff);

   fab_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fab_dp #(
      .NUM_FRAMES (NUM_FRAMES),
      .WORD_BITS  (WORD_BITS),
      .LIM_W      (LIM_W)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_tdata[fab_pkg::OP_W-1:0]),
      .req_frame_index (req_tdata[fab_pkg::OP_W +: fab_pkg::IDX_W]),
      .limit           (limit),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tdata       (rsp_tdata)
   );

endmodule
